>>> src/usf_pkg.sv
// Package: beat types, job type, error codes and key table for the rune scrambler.
package usf_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       stream_done;
    logic [2:0] error_code;
  } out_beat_t;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_LEAD  = 3'd1;
  localparam logic [2:0] ERR_BAD_CONT  = 3'd2;
  localparam logic [2:0] ERR_TRUNCATED = 3'd3;
  localparam logic [2:0] ERR_RANGE     = 3'd4;

  localparam logic [21:0] RUNE_MAX = 22'h10FFFF;
  localparam logic [21:0] SURR_LO  = 22'h00D800;
  localparam logic [21:0] SURR_HI  = 22'h00DFFF;

  // One job per result group: either an encoded rune or a single flag result.
  typedef struct packed {
    logic        is_rune;
    logic [20:0] value;
    logic [1:0]  count_m1;
    logic        done;
    logic [2:0]  err;
  } job_t;

  function automatic logic [7:0] key_byte(logic [3:0] idx);
    logic [7:0] k;
    case (idx)
      4'd0:    k = 8'h46;
      4'd1:    k = 8'h75;
      4'd2:    k = 8'h48;
      4'd3:    k = 8'h6F;
      4'd4:    k = 8'h6E;
      4'd5:    k = 8'h67;
      4'd6:    k = 8'h42;
      4'd7:    k = 8'h75;
      4'd8:    k = 8'h69;
      4'd9:    k = 8'h6C;
      4'd10:   k = 8'h64;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

endpackage

>>> src/usf_front.sv
// Front end: decodes UTF-8 bytes, scrambles finished runes, issues jobs.
module usf_front #(
  parameter int KEY_LENGTH = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  usf_pkg::in_beat_t in_data,
  output logic             job_push,
  output usf_pkg::job_t    job
);

  logic [2:0]  rune_length, rune_length_next;
  logic [2:0]  bytes_seen, bytes_seen_next;
  logic [20:0] acc, acc_next;
  logic [3:0]  key_pos, key_pos_next;
  logic [1:0]  off_pos, off_pos_next;
  logic        error_hold, error_hold_next;

  logic [7:0]  b;
  logic        last;
  logic [20:0] acc_in;
  logic [2:0]  len_in;
  logic [2:0]  seen_in;
  logic        bad;
  logic [2:0]  bad_code;
  logic [21:0] v;
  logic        v_bad;
  logic [4:0]  key_inc;

  always_comb begin
    b    = in_data.in_byte;
    last = in_data.in_last;
    bad      = 1'b0;
    bad_code = usf_pkg::ERR_NONE;
    acc_in   = acc;
    len_in   = rune_length;
    seen_in  = bytes_seen;
    if (bytes_seen == 3'd0) begin
      seen_in = 3'd1;
      if (b[7] == 1'b0) begin
        acc_in = {13'd0, b};
        len_in = 3'd1;
      end else if (b[7:5] == 3'b110) begin
        acc_in = {16'd0, b[4:0]};
        len_in = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
        acc_in = {17'd0, b[3:0]};
        len_in = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
        acc_in = {18'd0, b[2:0]};
        len_in = 3'd4;
      end else begin
        bad      = 1'b1;
        bad_code = usf_pkg::ERR_BAD_LEAD;
      end
    end else begin
      if (b[7:6] != 2'b10) begin
        bad      = 1'b1;
        bad_code = usf_pkg::ERR_BAD_CONT;
      end
      acc_in  = {acc[14:0], b[5:0]};
      seen_in = bytes_seen + 3'd1;
    end

    v = ({1'b0, acc_in} ^ {14'd0, usf_pkg::key_byte(key_pos)}) + {20'd0, off_pos};
    v_bad = (v > usf_pkg::RUNE_MAX) || (v >= usf_pkg::SURR_LO && v <= usf_pkg::SURR_HI);
    key_inc = {1'b0, key_pos} + 5'd1;

    rune_length_next = rune_length;
    bytes_seen_next  = bytes_seen;
    acc_next         = acc;
    key_pos_next     = key_pos;
    off_pos_next     = off_pos;
    error_hold_next  = error_hold;

    job_push     = 1'b0;
    job.is_rune  = 1'b0;
    job.value    = v[20:0];
    job.done     = last;
    job.err      = usf_pkg::ERR_NONE;
    if (v[21:0] <= 22'h7F)        job.count_m1 = 2'd0;
    else if (v[21:0] <= 22'h7FF)  job.count_m1 = 2'd1;
    else if (v[21:0] <= 22'hFFFF) job.count_m1 = 2'd2;
    else                          job.count_m1 = 2'd3;

    if (accept) begin
      if (error_hold) begin
        if (last) begin
          job_push = 1'b1;
        end
      end else begin
        if (!bad && seen_in >= len_in && v_bad) begin
          bad      = 1'b1;
          bad_code = usf_pkg::ERR_RANGE;
        end else if (!bad && seen_in < len_in && last) begin
          bad      = 1'b1;
          bad_code = usf_pkg::ERR_TRUNCATED;
        end
        if (bad) begin
          job_push = 1'b1;
          job.err  = bad_code;
          rune_length_next = 3'd0;
          bytes_seen_next  = 3'd0;
          acc_next         = 21'd0;
          error_hold_next  = 1'b1;
        end else if (seen_in >= len_in) begin
          job_push    = 1'b1;
          job.is_rune = 1'b1;
          rune_length_next = 3'd0;
          bytes_seen_next  = 3'd0;
          acc_next         = 21'd0;
          key_pos_next = (key_inc >= 5'(KEY_LENGTH)) ? 4'd0 : key_inc[3:0];
          off_pos_next = (off_pos == 2'd2) ? 2'd0 : off_pos + 2'd1;
        end else begin
          rune_length_next = len_in;
          bytes_seen_next  = seen_in;
          acc_next         = acc_in;
        end
      end
      if (last) begin
        rune_length_next = 3'd0;
        bytes_seen_next  = 3'd0;
        acc_next         = 21'd0;
        key_pos_next     = 4'd0;
        off_pos_next     = 2'd0;
        error_hold_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rune_length <= 3'd0;
      bytes_seen  <= 3'd0;
      acc         <= 21'd0;
      key_pos     <= 4'd0;
      off_pos     <= 2'd0;
      error_hold  <= 1'b0;
    end else begin
      rune_length <= rune_length_next;
      bytes_seen  <= bytes_seen_next;
      acc         <= acc_next;
      key_pos     <= key_pos_next;
      off_pos     <= off_pos_next;
      error_hold  <= error_hold_next;
    end
  end

endmodule

>>> src/usf_job_fifo.sv
// Short job queue between the decoder and the encoder.
module usf_job_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  usf_pkg::job_t wdata,
  input  logic          pop,
  output usf_pkg::job_t rdata,
  output logic          full,
  output logic          empty
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  usf_pkg::job_t    mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [AW:0]      count;
  logic             do_push, do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

endmodule

>>> src/usf_back.sv
// Back end: re-encodes jobs as result beats in output register, one per cycle if popped.
module usf_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  usf_pkg::job_t     job,
  output logic              job_pop,
  output logic              empty,
  input  logic              pop,
  output usf_pkg::out_beat_t out_data
);

  logic                valid;
  logic [1:0]          idx;
  logic                load;
  logic                final_beat;
  usf_pkg::out_beat_t  beat;
  logic [20:0]         v;

  assign empty      = !valid;
  assign load       = job_valid && (!valid || pop);
  assign final_beat = !job.is_rune || (idx == job.count_m1);
  assign job_pop    = load && final_beat;

  always_comb begin
    v = job.value;
    beat.out_last    = final_beat;
    beat.stream_done = job.done && final_beat;
    beat.error_code  = job.err;
    beat.out_byte    = 8'h00;
    if (job.is_rune) begin
      case ({job.count_m1, idx})
        4'b00_00: beat.out_byte = {1'b0, v[6:0]};
        4'b01_00: beat.out_byte = {3'b110, v[10:6]};
        4'b01_01: beat.out_byte = {2'b10, v[5:0]};
        4'b10_00: beat.out_byte = {4'b1110, v[15:12]};
        4'b10_01: beat.out_byte = {2'b10, v[11:6]};
        4'b10_10: beat.out_byte = {2'b10, v[5:0]};
        4'b11_00: beat.out_byte = {5'b11110, v[20:18]};
        4'b11_01: beat.out_byte = {2'b10, v[17:12]};
        4'b11_10: beat.out_byte = {2'b10, v[11:6]};
        4'b11_11: beat.out_byte = {2'b10, v[5:0]};
        default:  beat.out_byte = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
    end else begin
      if (load) begin
        valid <= 1'b1;
        idx   <= final_beat ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        valid <= 1'b0;
      end
    end
  end

endmodule

>>> src/utf8_rune_xor_scrambler.sv
// Top level of the UTF-8 rune scrambler: decoder, job queue, encoder.
// A byte that completes a rune pushes a job into the queue, and the encoder then loads
// its first result beat into the output register. The decoder takes one byte per cycle
// while the queue has room; the encoder gives one result beat per cycle while popped.
// A four-entry job queue lets the decoder keep taking bytes while the encoder drains.
// Synchronous reset clears decoder state, queue pointers and the output register valid.
module utf8_rune_xor_scrambler #(
  parameter int KEY_LENGTH = 11
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  usf_pkg::in_beat_t  in_data,
  output logic               empty,
  input  logic               pop,
  output usf_pkg::out_beat_t out_data
);

  logic          accept;
  logic          job_push, job_pop, job_empty;
  usf_pkg::job_t job_in, job_head;

  assign accept = push && !full;

  usf_front #(.KEY_LENGTH(KEY_LENGTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_data  (in_data),
    .job_push (job_push),
    .job      (job_in)
  );

  usf_job_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .pop   (job_pop),
    .rdata (job_head),
    .full  (full),
    .empty (job_empty)
  );

  usf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!job_empty),
    .job       (job_head),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule
